// File: rtl/fpm_pkg.sv
package fpm_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 4;
    localparam int SLOPE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_q15;
    typedef logic [CFG_W-1:0]          t_cfg;
    typedef logic signed [SLOPE_W-1:0] t_slope;

    localparam t_cmd CMD_WRITE  = 2'd0;
    localparam t_cmd CMD_DERIVE = 2'd1;
    localparam t_cmd CMD_EVAL   = 2'd2;

    localparam t_cfg   CFG_RESET  = 4'd8;
    localparam t_q15   ONE_Q15    = 16'h8000;
    localparam t_q15   ROUND_BIAS = 16'hFFFF;
    localparam t_slope SLOPE_MAX  = 32'sh7FFF_FFFF;
    localparam t_slope SLOPE_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic pt_wr;
        logic pt_rd;
        logic sl_rd;
        logic sl_wr;
        logic smp_ld;
        logic prev_ld;
        logic best_clr;
        logic mul_ld;
        logic acc_upd;
        logic div_start;
        logic out_ld;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

// File: rtl/fpm_if.sv
interface fpm_in_if import fpm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_idx   set_index;
    t_idx   point_index;
    t_coord point_x;
    t_q15   point_y;
    t_coord sample_x;

    modport source (
        output valid, cmd, set_index, point_index, point_x, point_y, sample_x,
        input  ready
    );
    modport sink (
        input  valid, cmd, set_index, point_index, point_x, point_y, sample_x,
        output ready
    );
endinterface

interface fpm_out_if import fpm_pkg::*; ();
    logic valid;
    logic ready;
    t_idx result_set;
    t_q15 membership;
    logic last;

    modport source (
        output valid, result_set, membership, last,
        input  ready
    );
    modport sink (
        input  valid, result_set, membership, last,
        output ready
    );
endinterface

// File: rtl/fpm_ram.sv
module fpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fpm_div.sv
module fpm_div import fpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_quot;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;

    logic [DIV_D_W:0] rem_sh;
    logic [DIV_D_W:0] rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DIV_N_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_N_W-2:0], ge};
            r_rem  <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/fpm_ctrl.sv
module fpm_ctrl import fpm_pkg::*; #(
    parameter int NUM_SETS = 8,
    parameter int SEGMENTS = 4,
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
    localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1,
    localparam int PT_W  = $clog2(SEGMENTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg             i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_cmd             i_in_cmd,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_dp_cmd          o_cmd,
    input  t_dp_sts          i_sts,
    output logic [SET_W-1:0] o_set,
    output logic [SEG_W-1:0] o_seg,
    output logic [SET_W-1:0] o_rd_set,
    output logic [PT_W-1:0]  o_rd_pt,
    output logic [SEG_W-1:0] o_rd_seg
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LD0    = 4'd1;
    localparam logic [3:0] S_SEG    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_OUT    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DDIV   = 4'd6;
    localparam logic [3:0] S_DWR    = 4'd7;

    logic [3:0]       r_state, n_state;
    logic             r_eval, n_eval;
    logic [SET_W-1:0] r_set, n_set;
    logic [SEG_W-1:0] r_seg, n_seg;
    logic             r_out_vld, n_out_vld;
    t_cfg             r_cfg;

    logic [SET_W-1:0] last_set;
    logic             in_acc;
    logic             out_free;
    logic             seg_last;
    logic             set_last;
    t_dp_cmd          cmd;
    logic [SET_W-1:0] rd_set;
    logic [PT_W-1:0]  rd_pt;
    logic [SEG_W-1:0] rd_seg;

    always_comb begin
        if (r_cfg == '0) begin
            last_set = '0;
        end else if (int'(r_cfg) >= NUM_SETS) begin
            last_set = SET_W'(NUM_SETS - 1);
        end else begin
            last_set = SET_W'(r_cfg - 4'd1);
        end
    end

    always_comb begin
        in_acc    = i_in_valid && (r_state == S_IDLE);
        out_free  = !r_out_vld || i_out_ready;
        seg_last  = r_seg == SEG_W'(SEGMENTS - 1);
        set_last  = r_set == last_set;
        n_state   = r_state;
        n_eval    = r_eval;
        n_set     = r_set;
        n_seg     = r_seg;
        cmd       = '0;
        rd_set    = r_set;
        rd_pt     = '0;
        rd_seg    = r_seg;

        unique case (r_state)
            S_IDLE: begin
                rd_set = '0;
                rd_seg = '0;
                if (in_acc) begin
                    if (i_in_cmd == CMD_WRITE) begin
                        cmd.pt_wr = 1'b1;
                    end else if (i_in_cmd == CMD_DERIVE || i_in_cmd == CMD_EVAL) begin
                        cmd.pt_rd  = 1'b1;
                        cmd.smp_ld = i_in_cmd == CMD_EVAL;
                        n_eval     = i_in_cmd == CMD_EVAL;
                        n_set      = '0;
                        n_seg      = '0;
                        n_state    = S_LD0;
                    end
                end
            end
            S_LD0: begin
                cmd.prev_ld = 1'b1;
                cmd.pt_rd   = 1'b1;
                rd_pt       = PT_W'(1);
                if (r_eval) begin
                    cmd.sl_rd    = 1'b1;
                    cmd.best_clr = 1'b1;
                    n_state      = S_SEG;
                end else begin
                    n_state = S_DSTART;
                end
            end
            S_SEG: begin
                cmd.mul_ld = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                cmd.acc_upd = 1'b1;
                cmd.prev_ld = 1'b1;
                if (seg_last) begin
                    n_state = S_OUT;
                end else begin
                    cmd.pt_rd = 1'b1;
                    cmd.sl_rd = 1'b1;
                    rd_pt     = PT_W'(r_seg) + PT_W'(2);
                    rd_seg    = r_seg + SEG_W'(1);
                    n_seg     = r_seg + SEG_W'(1);
                    n_state   = S_SEG;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_last = set_last;
                    if (set_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.pt_rd = 1'b1;
                        rd_set    = r_set + SET_W'(1);
                        n_set     = r_set + SET_W'(1);
                        n_seg     = '0;
                        n_state   = S_LD0;
                    end
                end
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                n_state       = S_DDIV;
            end
            S_DDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                cmd.sl_wr   = 1'b1;
                cmd.prev_ld = 1'b1;
                if (!seg_last) begin
                    cmd.pt_rd = 1'b1;
                    rd_pt     = PT_W'(r_seg) + PT_W'(2);
                    n_seg     = r_seg + SEG_W'(1);
                    n_state   = S_DSTART;
                end else if (!set_last) begin
                    cmd.pt_rd = 1'b1;
                    rd_set    = r_set + SET_W'(1);
                    n_set     = r_set + SET_W'(1);
                    n_seg     = '0;
                    n_state   = S_LD0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.out_ld) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_eval    <= 1'b0;
            r_set     <= '0;
            r_seg     <= '0;
            r_out_vld <= 1'b0;
            r_cfg     <= CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_eval    <= n_eval;
            r_set     <= n_set;
            r_seg     <= n_seg;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;
    assign o_set       = r_set;
    assign o_seg       = r_seg;
    assign o_rd_set    = rd_set;
    assign o_rd_pt     = rd_pt;
    assign o_rd_seg    = rd_seg;

endmodule

// File: rtl/fpm_dpath.sv
module fpm_dpath import fpm_pkg::*; #(
    parameter int NUM_SETS = 8,
    parameter int SEGMENTS = 4,
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
    localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1,
    localparam int PT_W  = $clog2(SEGMENTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [SET_W-1:0] i_set,
    input  logic [SEG_W-1:0] i_seg,
    input  logic [SET_W-1:0] i_rd_set,
    input  logic [PT_W-1:0]  i_rd_pt,
    input  logic [SEG_W-1:0] i_rd_seg,
    input  t_idx             i_wr_set,
    input  t_idx             i_wr_pt,
    input  t_coord           i_point_x,
    input  t_q15             i_point_y,
    input  t_coord           i_sample_x,
    output t_idx             o_result_set,
    output t_q15             o_membership,
    output logic             o_last
);

    localparam int PTS    = SEGMENTS + 1;
    localparam int PT_DEP = NUM_SETS * PTS;
    localparam int SL_DEP = NUM_SETS * SEGMENTS;
    localparam int PA_W   = (PT_DEP > 1) ? $clog2(PT_DEP) : 1;
    localparam int SA_W   = (SL_DEP > 1) ? $clog2(SL_DEP) : 1;
    localparam int PROD_W = SLOPE_W + COORD_W + 1;
    localparam int QUO_W  = PROD_W - FRAC_W;
    localparam int VAL_W  = QUO_W + 2;
    localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(ONE_Q15);

    logic                 pt_wr_en;
    logic [PA_W-1:0]      pt_wr_addr;
    logic [PA_W-1:0]      pt_rd_addr;
    logic [2*COORD_W-1:0] pt_rdata;
    logic [SA_W-1:0]      sl_wr_addr;
    logic [SA_W-1:0]      sl_rd_addr;
    logic [SLOPE_W-1:0]   sl_rdata;
    t_slope               sl_wdata;
    t_coord               ram_x;
    t_q15                 ram_y;

    t_coord                    r_prev_x;
    t_q15                      r_prev_y;
    t_coord                    r_sample;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_inr;
    t_q15                      r_best;
    logic                      r_neg;
    logic                      r_dx_zero;
    logic                      r_dy_nz;
    t_idx                      r_res_set;
    t_q15                      r_memb;
    logic                      r_last;

    logic signed [COORD_W:0]   diff_smp;
    logic                      in_range;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [QUO_W-1:0]   quo;
    logic signed [VAL_W-1:0]   val;
    logic signed [VAL_W-1:0]   val_cl;
    logic                      best_upd;

    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic signed [COORD_W:0]   dx_neg;
    logic signed [COORD_W:0]   dy_neg;
    logic [DIV_D_W-1:0]        adx;
    logic [DIV_D_W-1:0]        ady;
    logic                      div_done;
    logic [DIV_N_W-1:0]        quot;
    logic [DIV_N_W-1:0]        quot_neg;

    always_comb begin
        pt_wr_en   = i_cmd.pt_wr && (int'(i_wr_set) < NUM_SETS) && (int'(i_wr_pt) <= SEGMENTS);
        pt_wr_addr = PA_W'(PTS * int'(i_wr_set) + int'(i_wr_pt));
        pt_rd_addr = PA_W'(PTS * int'(i_rd_set) + int'(i_rd_pt));
        sl_wr_addr = SA_W'(SEGMENTS * int'(i_set) + int'(i_seg));
        sl_rd_addr = SA_W'(SEGMENTS * int'(i_rd_set) + int'(i_rd_seg));
        ram_x      = pt_rdata[2*COORD_W-1:COORD_W];
        ram_y      = pt_rdata[COORD_W-1:0];
    end

    fpm_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (PT_DEP)
    ) u_pt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pt_wr_en),
        .i_wr_addr (pt_wr_addr),
        .i_wr_data ({i_point_x, i_point_y}),
        .i_rd_en   (i_cmd.pt_rd),
        .i_rd_addr (pt_rd_addr),
        .o_rd_data (pt_rdata)
    );

    fpm_ram #(
        .WIDTH (SLOPE_W),
        .DEPTH (SL_DEP)
    ) u_sl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.sl_wr),
        .i_wr_addr (sl_wr_addr),
        .i_wr_data (sl_wdata),
        .i_rd_en   (i_cmd.sl_rd),
        .i_rd_addr (sl_rd_addr),
        .o_rd_data (sl_rdata)
    );

    always_comb begin
        diff_smp = {r_sample[COORD_W-1], r_sample} - {r_prev_x[COORD_W-1], r_prev_x};
        in_range = (r_sample >= r_prev_x) && (r_sample <= ram_x);
        prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(ROUND_BIAS) : PROD_W'(0));
        quo      = prod_adj[PROD_W-1:FRAC_W];
        val      = $signed({{2{quo[QUO_W-1]}}, quo}) + $signed(VAL_W'(r_prev_y));
        val_cl   = (val > ONE_V) ? ONE_V : val;
        best_upd = r_inr && (val_cl > $signed(VAL_W'(r_best)));
    end

    always_comb begin
        dx     = {ram_x[COORD_W-1], ram_x} - {r_prev_x[COORD_W-1], r_prev_x};
        dy     = $signed({1'b0, ram_y}) - $signed({1'b0, r_prev_y});
        dx_neg = -dx;
        dy_neg = -dy;
        adx    = dx[COORD_W] ? dx_neg[DIV_D_W-1:0] : dx[DIV_D_W-1:0];
        ady    = dy[COORD_W] ? dy_neg[DIV_D_W-1:0] : dy[DIV_D_W-1:0];
    end

    fpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({ady, {FRAC_W{1'b0}}}),
        .i_divisor  (adx),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        quot_neg = -quot;
        if (r_dx_zero) begin
            sl_wdata = r_dy_nz ? SLOPE_MAX : '0;
        end else if (!r_neg) begin
            sl_wdata = quot[DIV_N_W-1] ? SLOPE_MAX : $signed(quot);
        end else if (quot > DIV_N_W'(SLOPE_MIN)) begin
            sl_wdata = SLOPE_MIN;
        end else begin
            sl_wdata = $signed(quot_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_ld) begin
            r_sample <= i_sample_x;
        end
        if (i_cmd.prev_ld) begin
            r_prev_x <= ram_x;
            r_prev_y <= ram_y;
        end
        if (i_cmd.mul_ld) begin
            r_prod <= $signed(sl_rdata) * diff_smp;
            r_inr  <= in_range;
        end
        if (i_cmd.best_clr) begin
            r_best <= '0;
        end else if (i_cmd.acc_upd && best_upd) begin
            r_best <= val_cl[COORD_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_neg     <= dx[COORD_W] ^ dy[COORD_W];
            r_dx_zero <= dx == '0;
            r_dy_nz   <= dy != '0;
        end
        if (i_cmd.out_ld) begin
            r_res_set <= IDX_W'(i_set);
            r_memb    <= r_best;
            r_last    <= i_cmd.out_last;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_result_set   = r_res_set;
    assign o_membership   = r_memb;
    assign o_last         = r_last;

endmodule

// File: rtl/fuzzy_piecewise_membership.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    cmd, set_index, point_index, point_x, point_y, sample_x
// o_out     out  valid/ready    result_set, membership, last
// i_cfg_*   in   write enable   num_sets_in_use (4 bits)
//
// Write: the block stays ready. Evaluate: per function in use, one point RAM read
// and one multiply-accumulate per segment. Derive: one divide per segment by the
// serial divider (one quotient bit a cycle), which the walk waits on.
// Reset i_rst_n is synchronous: state idle, output empty, num_sets_in_use = 8.
// A stalled o_out holds the result and stops the evaluate walk at its next result until the transfer.
module fuzzy_piecewise_membership import fpm_pkg::*; #(
    parameter int NUM_SETS = 8,
    parameter int SEGMENTS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg       i_cfg_wdata,
    fpm_in_if.sink     i_in,
    fpm_out_if.source  o_out
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int PT_W  = $clog2(SEGMENTS + 1);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [SET_W-1:0] set;
    logic [SEG_W-1:0] seg;
    logic [SET_W-1:0] rd_set;
    logic [PT_W-1:0]  rd_pt;
    logic [SEG_W-1:0] rd_seg;

    fpm_ctrl #(
        .NUM_SETS (NUM_SETS),
        .SEGMENTS (SEGMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_set       (set),
        .o_seg       (seg),
        .o_rd_set    (rd_set),
        .o_rd_pt     (rd_pt),
        .o_rd_seg    (rd_seg)
    );

    fpm_dpath #(
        .NUM_SETS (NUM_SETS),
        .SEGMENTS (SEGMENTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_set        (set),
        .i_seg        (seg),
        .i_rd_set     (rd_set),
        .i_rd_pt      (rd_pt),
        .i_rd_seg     (rd_seg),
        .i_wr_set     (i_in.set_index),
        .i_wr_pt      (i_in.point_index),
        .i_point_x    (i_in.point_x),
        .i_point_y    (i_in.point_y),
        .i_sample_x   (i_in.sample_x),
        .o_result_set (o_out.result_set),
        .o_membership (o_out.membership),
        .o_last       (o_out.last)
    );

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over an untaken result");

    a_wr_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pt_wr |-> (i_in.valid && i_in.ready && i_in.cmd == CMD_WRITE))
        else $error("breakpoint write without an input transfer");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_ld && cmd.out_last) |=> i_in.ready)
        else $error("input not ready after the final result of a sample");

endmodule

// File: bench/fuzzy_piecewise_membership_checker.sv
module fuzzy_piecewise_membership_checker import fpm_pkg::*; #(
    parameter int NUM_SETS = 8,
    parameter int SEGMENTS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  t_cfg i_cfg_wdata,
    fpm_in_if    i_in,
    fpm_out_if   i_out,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int POINTS     = SEGMENTS + 1;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        t_idx result_set;
        t_q15 membership;
        logic last;
    } t_degree;

    t_coord  knot_x [NUM_SETS*POINTS];
    t_q15    knot_y [NUM_SETS*POINTS];
    t_slope  gradient [NUM_SETS*SEGMENTS];
    t_cfg    sets_reg;
    t_degree degree_queue [$];
    int      mismatch_cnt;

    initial begin
        for (int k = 0; k < NUM_SETS*POINTS; k++) begin
            knot_x[k] = '0;
            knot_y[k] = '0;
        end
        for (int k = 0; k < NUM_SETS*SEGMENTS; k++) begin
            gradient[k] = '0;
        end
        sets_reg      = CFG_RESET;
        mismatch_cnt  = 0;
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < PRINT_LIMIT) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_cnt++;
    endtask

    function automatic int live_sets();
        if (sets_reg == 0) begin
            return 1;
        end
        if (int'(sets_reg) > NUM_SETS) begin
            return NUM_SETS;
        end
        return int'(sets_reg);
    endfunction

    function automatic void derive_gradients();
        longint dy, dx, q;
        int     base;
        for (int s = 0; s < live_sets(); s++) begin
            for (int g = 0; g < SEGMENTS; g++) begin
                base = s*POINTS + g;
                dy = longint'(knot_y[base+1]) - longint'(knot_y[base]);
                dx = longint'(knot_x[base+1]) - longint'(knot_x[base]);
                if (dx == 0) begin
                    q = (dy != 0) ? longint'(SLOPE_MAX) : 0;
                end else begin
                    q = (dy * 65536) / dx;
                    if (q > longint'(SLOPE_MAX)) q = longint'(SLOPE_MAX);
                    if (q < longint'(SLOPE_MIN)) q = longint'(SLOPE_MIN);
                end
                gradient[s*SEGMENTS + g] = t_slope'(q);
            end
        end
    endfunction

    function automatic t_q15 membership_of(input int s, input t_coord x);
        longint best, v, prod;
        int     base;
        best = 0;
        for (int g = 0; g < SEGMENTS; g++) begin
            base = s*POINTS + g;
            if (x >= knot_x[base] && x <= knot_x[base+1]) begin
                prod = longint'(gradient[s*SEGMENTS + g])
                     * (longint'(x) - longint'(knot_x[base]));
                v = longint'(knot_y[base]) + prod / 65536;
                if (v > longint'(ONE_Q15)) v = longint'(ONE_Q15);
                if (v > best) best = v;
            end
        end
        return t_q15'(best);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_degree want;
        int      n, k;
        if (!i_rst_n) begin
            sets_reg = CFG_RESET;
            degree_queue.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (degree_queue.size() == 0) begin
                    report_mismatch("result with none pending, set", i_out.result_set, -1);
                end else begin
                    want = degree_queue.pop_front();
                    if (i_out.result_set !== want.result_set)
                        report_mismatch("result_set", i_out.result_set, want.result_set);
                    if (i_out.membership !== want.membership)
                        report_mismatch("membership", i_out.membership, want.membership);
                    if (i_out.last !== want.last)
                        report_mismatch("last", i_out.last, want.last);
                end
            end
            if (i_cfg_we) begin
                sets_reg = i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.cmd)
                    CMD_WRITE: begin
                        if (int'(i_in.set_index) < NUM_SETS && int'(i_in.point_index) <= SEGMENTS) begin
                            k = int'(i_in.set_index)*POINTS + int'(i_in.point_index);
                            knot_x[k] = i_in.point_x;
                            knot_y[k] = i_in.point_y;
                        end
                    end
                    CMD_DERIVE: begin
                        derive_gradients();
                    end
                    CMD_EVAL: begin
                        n = live_sets();
                        for (int s = 0; s < n; s++) begin
                            want.result_set = t_idx'(s);
                            want.membership = membership_of(s, i_in.sample_x);
                            want.last       = (s == n - 1);
                            degree_queue.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_outstanding <= degree_queue.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

// File: bench/fuzzy_piecewise_membership_tb.sv
module fuzzy_piecewise_membership_tb;
    import fpm_pkg::*;

    localparam int   NUM_SETS    = 8;
    localparam int   SEGMENTS    = 4;
    localparam int   POINTS      = SEGMENTS + 1;
    localparam int   HOLD_OFF    = 400;
    localparam int   SETTLE      = 2000;
    localparam int   STALL_LIMIT = 20000;
    localparam t_cmd CMD_UNUSED  = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_cfg cfg_wdata;
    int   mismatches;
    int   outstanding;

    bit   hold_off_go;
    bit   flood;
    int   in_run;
    bit   in_quiet;
    t_cfg cfg_now;
    int   shape_x [POINTS];

    fpm_in_if  in_ch ();
    fpm_out_if out_ch ();

    fuzzy_piecewise_membership #(
        .NUM_SETS (NUM_SETS),
        .SEGMENTS (SEGMENTS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    fuzzy_piecewise_membership_checker #(
        .NUM_SETS (NUM_SETS),
        .SEGMENTS (SEGMENTS)
    ) degree_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int next_gap(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(4, 24);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic t_coord to_coord(input int v);
        if (v < -32768) return t_coord'(-32768);
        if (v > 32767) return t_coord'(32767);
        return t_coord'(v);
    endfunction

    task automatic send(input t_cmd c, input t_idx s, input t_idx p,
                        input t_coord px, input t_q15 py, input t_coord sx);
        int gap;
        gap = flood ? 0 : next_gap(in_run, in_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= c;
        in_ch.set_index   <= s;
        in_ch.point_index <= p;
        in_ch.point_x     <= px;
        in_ch.point_y     <= py;
        in_ch.sample_x    <= sx;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic put_point(input t_idx s, input t_idx p, input t_coord x, input t_q15 y);
        send(CMD_WRITE, s, p, x, y, t_coord'($urandom));
    endtask

    task automatic eval_at(input t_coord x);
        send(CMD_EVAL, t_idx'($urandom), t_idx'($urandom), t_coord'($urandom),
             t_q15'($urandom), x);
    endtask

    task automatic derive_all();
        send(CMD_DERIVE, t_idx'($urandom), t_idx'($urandom), t_coord'($urandom),
             t_q15'($urandom), t_coord'($urandom));
    endtask

    task automatic reconfigure(input t_cfg v);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cfg_now    = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_shape(input t_idx s);
        int   centre, span, tmp, k;
        t_q15 y;
        centre = int'($urandom_range(0, 65535)) - 32768;
        span   = ($urandom_range(0, 1) == 0) ? 40 : 32768;
        for (int i = 0; i < POINTS; i++) begin
            shape_x[i] = centre + int'($urandom_range(0, 2*span)) - span;
        end
        for (int i = 0; i < POINTS-1; i++) begin
            for (int j = 0; j < POINTS-1-i; j++) begin
                if (shape_x[j] > shape_x[j+1]) begin
                    tmp          = shape_x[j];
                    shape_x[j]   = shape_x[j+1];
                    shape_x[j+1] = tmp;
                end
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, POINTS-2);
            shape_x[k+1] = shape_x[k];
        end
        if ($urandom_range(0, 7) == 0) begin
            tmp               = shape_x[0];
            shape_x[0]        = shape_x[POINTS-1];
            shape_x[POINTS-1] = tmp;
        end
        for (int i = 0; i < POINTS; i++) begin
            if ($urandom_range(0, 7) == 0) y = t_q15'($urandom);
            else y = t_q15'($urandom_range(0, 32768));
            put_point(s, t_idx'(i), to_coord(shape_x[i]), y);
        end
    endtask

    task automatic random_run(input int count);
        int   done, active, n;
        t_idx s;
        t_cmd c;
        done   = 0;
        active = (cfg_now == 0) ? 1 : ((int'(cfg_now) > NUM_SETS) ? NUM_SETS : int'(cfg_now));
        while (done < count) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 4) != 0) s = t_idx'($urandom_range(0, active-1));
                else s = t_idx'($urandom_range(0, NUM_SETS-1));
                random_shape(s);
                done += POINTS;
                if ($urandom_range(0, 3) != 0) begin
                    derive_all();
                    done++;
                end
                n = $urandom_range(2, 5);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) eval_at(t_coord'($urandom));
                    else eval_at(to_coord(shape_x[$urandom_range(0, POINTS-1)]
                                          + int'($urandom_range(0, 6)) - 3));
                end
                done += n;
            end else begin
                c = t_cmd'($urandom_range(0, 3));
                send(c, t_idx'($urandom), t_idx'($urandom), t_coord'($urandom),
                     t_q15'($urandom), t_coord'($urandom));
                if (c != CMD_UNUSED) done++;
            end
        end
    endtask

    initial begin : result_sink
        int stall, run_left;
        bit quiet, held;
        run_left = 0;
        quiet    = 1'b0;
        held     = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_off_go && !held) begin
                held  = 1'b1;
                stall = HOLD_OFF;
            end else begin
                stall = next_gap(run_left, quiet);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_WRITE;
        in_ch.set_index   <= '0;
        in_ch.point_index <= '0;
        in_ch.point_x     <= '0;
        in_ch.point_y     <= '0;
        in_ch.sample_x    <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        hold_off_go       <= 1'b0;
        flood    = 1'b0;
        in_run   = 0;
        in_quiet = 1'b0;
        cfg_now  = CFG_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        reconfigure(CFG_RESET);
        for (int s = 0; s < NUM_SETS; s++) begin
            random_shape(t_idx'(s));
        end
        derive_all();

        // flat zero-width segment, saturated slope, height above 1.0
        put_point(0, 0, -32768, 16'h0000);
        put_point(0, 1, -1, 16'hFFFF);
        put_point(0, 2, -1, 16'hFFFF);
        put_point(0, 3, 0, 16'h0000);
        put_point(0, 4, 32767, ONE_Q15);
        // unsorted breakpoints
        put_point(1, 0, 100, 16'h0000);
        put_point(1, 1, 50, ONE_Q15);
        put_point(1, 2, -200, 16'd100);
        put_point(1, 3, -200, 16'd5000);
        put_point(1, 4, 300, 16'd20000);
        send(CMD_UNUSED, 3'd7, 3'd7, -1, 16'hFFFF, -1);
        put_point(2, 5, 123, 16'd456);
        put_point(2, 7, -5, 16'd9);
        derive_all();
        eval_at(-32768);
        eval_at(-1);
        eval_at(0);
        eval_at(32767);
        eval_at(100);
        eval_at(-200);
        eval_at(75);

        reconfigure(4'd1);
        random_run(20);
        reconfigure(4'd0);
        random_run(20);
        reconfigure(4'd15);
        random_run(20);
        hold_off_go <= 1'b1;
        flood = 1'b1;
        repeat (10) eval_at(t_coord'($urandom));
        flood = 1'b0;
        reconfigure(4'd3);
        random_run(20);
        reconfigure(CFG_RESET);
        random_run(20);
        reconfigure(4'd6);
        random_run(20);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
